// File: sv/hsjog_pkg.sv
package hsjog_pkg;

	// Width of the step period and of the tick counter
	localparam int PERIOD_BITS = 16;
	// Width of the configuration registers and of the reported period
	localparam int REG_BITS    = 16;
	localparam int CMP_BITS    = (PERIOD_BITS > REG_BITS) ? PERIOD_BITS : REG_BITS;

	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_RATE   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RATE_FLOOR   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RATE_CEILING = 2'd2;

	localparam logic [REG_BITS-1:0] START_RATE_RST   = 16'd12000;
	localparam logic [REG_BITS-1:0] RATE_FLOOR_RST   = 16'd5000;
	localparam logic [REG_BITS-1:0] RATE_CEILING_RST = 16'd60000;

	// Bit positions of the switch levels (active low)
	localparam int PIN_FWD  = 3;
	localparam int PIN_REV  = 2;
	localparam int PIN_FAST = 1;
	localparam int PIN_SLOW = 0;

	// period / 1000 as a multiply by a rounded-up reciprocal and a shift;
	// the rounding error stays below 1/1000 over the whole period range
	localparam int SHRINK_DIV = 1000;
	localparam int DIV_SHIFT  = PERIOD_BITS + 10;
	localparam longint unsigned DIV_RECIP_L =
		((64'd1 << DIV_SHIFT) + 64'(SHRINK_DIV - 1)) / 64'(SHRINK_DIV);
	localparam logic [PERIOD_BITS:0] DIV_RECIP = DIV_RECIP_L[PERIOD_BITS:0];

	typedef logic [PERIOD_BITS-1:0] period_t;
	typedef logic [REG_BITS-1:0]    reg_t;

	typedef struct packed {
		reg_t rate_floor;
		reg_t rate_ceiling;
	} limits_t;

	typedef struct packed {
		logic       coils_released;
		reg_t       step_period;
		logic [2:0] step_position;
		logic [3:0] coil_drive;
	} result_t;

	// Half-step coil pattern
	function automatic logic [3:0] coil_nibble(input logic [2:0] idx);
		logic [3:0] nib;
		case (idx)
			3'd0: nib = 4'hA;
			3'd1: nib = 4'h8;
			3'd2: nib = 4'h9;
			3'd3: nib = 4'h1;
			3'd4: nib = 4'h5;
			3'd5: nib = 4'h4;
			3'd6: nib = 4'h6;
			3'd7: nib = 4'h2;
			default: nib = 4'h0;
		endcase
		return nib;
	endfunction

endpackage

// File: sv/half_step_stepper_jog_control_top.sv
// Latency: a tick that ends a step period gives its result beat in the next cycle.
// Throughput: one tick per cycle; only the output register backpressures the input.
// The period divide by 1000 is a reciprocal multiply, registered from the held period.
// Reset (arst_n low, asynchronous): floor and ceiling to 5000/60000, period 12000,
// tick count, half-step index and release cleared, no result pending.
module half_step_stepper_jog_control_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [3:0] switch_levels
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [3:0] coil_drive, [6:4] step_position, [22:7] step_period, [23] coils_released
	output logic [23:0]                       m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hsjog_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [15:0]                       cfg_data
);

	hsjog_pkg::limits_t limits_q;
	hsjog_pkg::result_t result;
	logic               cfg_wr;
	logic               period_load;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign period_load = cfg_wr && (cfg_index == hsjog_pkg::REG_START_RATE);

	// Hold floor and ceiling; the start rate goes straight into the period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.rate_floor   <= hsjog_pkg::RATE_FLOOR_RST;
			limits_q.rate_ceiling <= hsjog_pkg::RATE_CEILING_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				hsjog_pkg::REG_RATE_FLOOR:   limits_q.rate_floor   <= cfg_data;
				hsjog_pkg::REG_RATE_CEILING: limits_q.rate_ceiling <= cfg_data;
				default: ;
			endcase
		end
	end

	hsjog_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (s_axis_tvalid),
		.in_rdy        (s_axis_tready),
		.switch_levels (s_axis_tdata[3:0]),
		.out_vld       (m_axis_tvalid),
		.out_rdy       (m_axis_tready),
		.out_data      (result),
		.limits        (limits_q),
		.period_load   (period_load),
		.period_value  (cfg_data)
	);

	assign m_axis_tdata = result;

`ifndef ASSERT_OFF
	// A held result must block new ticks
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while result stalled");

	// A new result only follows an accepted tick
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("result without accepted tick");

	// Released coils are only driven on the step that set the release
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && $past(s_axis_tvalid && s_axis_tready) &&
		m_axis_tdata[23] && (m_axis_tdata[3:0] != 4'h0))
		|-> $past(!s_axis_tdata[1] && !s_axis_tdata[0]))
		else $error("coils driven while released");
`endif

endmodule

// File: sv/hsjog_div.sv
module hsjog_div (
	input  logic                clk,
	input  hsjog_pkg::period_t  period,
	output hsjog_pkg::period_t  quot
);

	logic [2*hsjog_pkg::PERIOD_BITS:0] prod;
	hsjog_pkg::period_t                quot_s1;

	// Multiply by the reciprocal and drop the fraction
	always_comb begin
		prod = (2*hsjog_pkg::PERIOD_BITS+1)'(period) *
			(2*hsjog_pkg::PERIOD_BITS+1)'(hsjog_pkg::DIV_RECIP);
	end

	// Hold the quotient for the step logic of the next cycle
	always_ff @(posedge clk) begin
		quot_s1 <= hsjog_pkg::PERIOD_BITS'(prod >> hsjog_pkg::DIV_SHIFT);
	end

	assign quot = quot_s1;

endmodule

// File: sv/hsjog_core.sv
module hsjog_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	output logic                in_rdy,
	input  logic [3:0]          switch_levels,
	output logic                out_vld,
	input  logic                out_rdy,
	output hsjog_pkg::result_t  out_data,
	input  hsjog_pkg::limits_t  limits,
	input  logic                period_load,
	input  hsjog_pkg::reg_t     period_value
);

	hsjog_pkg::period_t   tick_q;
	hsjog_pkg::period_t   period_q;
	logic [2:0]           pos_q;
	logic                 rel_q;
	logic                 out_vld_q;
	hsjog_pkg::result_t   out_q;

	hsjog_pkg::period_t   quot;
	hsjog_pkg::period_t   shrink;
	hsjog_pkg::period_t   period_new;
	logic [hsjog_pkg::PERIOD_BITS:0] grown;
	logic [hsjog_pkg::CMP_BITS-1:0]  cmp_period;
	logic [3:0]           pressed;
	logic                 fwd, rev, fast, slow;
	logic                 expire, accept;
	logic [2:0]           pos_fwd, pos_new;
	logic                 rel_mid, rel_new;
	logic [3:0]           coil_new;

	hsjog_div u_div (
		.clk    (clk),
		.period (period_q),
		.quot   (quot)
	);

	// Take a tick whenever the result register is free or being emptied
	assign in_rdy = !out_vld_q || out_rdy;
	assign accept = in_vld && in_rdy;

	// Step decision and the new state for a stepping tick
	always_comb begin
		pressed    = ~switch_levels;
		fwd        = pressed[hsjog_pkg::PIN_FWD];
		rev        = pressed[hsjog_pkg::PIN_REV];
		fast       = pressed[hsjog_pkg::PIN_FAST];
		slow       = pressed[hsjog_pkg::PIN_SLOW];
		expire     = tick_q >= period_q;
		// a zero period right after a load has no quotient yet; it is zero anyway
		shrink     = (period_q == '0) ? '0 : quot;
		pos_fwd    = fwd ? pos_q + 3'd1 : pos_q;
		pos_new    = rev ? pos_fwd - 3'd1 : pos_fwd;
		rel_mid    = rel_q && !(fwd || rev);
		coil_new   = rel_mid ? 4'h0 : hsjog_pkg::coil_nibble(pos_new);
		cmp_period = hsjog_pkg::CMP_BITS'(period_q);
		grown      = {1'b0, period_q} + {1'b0, shrink};
		period_new = period_q;
		if (fast) begin
			if (cmp_period > hsjog_pkg::CMP_BITS'(limits.rate_floor)) begin
				period_new = period_q - shrink;
			end
		end else if (slow) begin
			if (cmp_period < hsjog_pkg::CMP_BITS'(limits.rate_ceiling)) begin
				period_new = grown[hsjog_pkg::PERIOD_BITS] ? '1 :
					grown[hsjog_pkg::PERIOD_BITS-1:0];
			end
		end
		rel_new    = rel_mid || (fast && slow);
	end

	// Advance the timer and the motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			period_q <= hsjog_pkg::PERIOD_BITS'(hsjog_pkg::START_RATE_RST);
			pos_q    <= 3'd0;
			rel_q    <= 1'b0;
		end else if (period_load) begin
			tick_q   <= '0;
			period_q <= hsjog_pkg::PERIOD_BITS'(period_value);
		end else if (accept) begin
			if (expire) begin
				tick_q   <= '0;
				period_q <= period_new;
				pos_q    <= pos_new;
				rel_q    <= rel_new;
			end else begin
				tick_q   <= tick_q + 1'b1;
			end
		end
	end

	// Result register: fill on a step, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept && expire) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && expire) begin
			out_q.coil_drive     <= coil_new;
			out_q.step_position  <= pos_new;
			out_q.step_period    <= hsjog_pkg::REG_BITS'(period_new);
			out_q.coils_released <= rel_new;
		end
	end

	assign out_vld  = out_vld_q;
	assign out_data = out_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_GAP       = 19;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 750;

	// Index with no register behind it
	localparam logic [hsjog_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	// Switch levels, active low: bit3 forward, bit2 reverse, bit1 fast, bit0 slow
	localparam logic [3:0] SW_NONE        = 4'hF;
	localparam logic [3:0] SW_FWD         = 4'h7;
	localparam logic [3:0] SW_REV         = 4'hB;
	localparam logic [3:0] SW_FAST        = 4'hD;
	localparam logic [3:0] SW_SLOW        = 4'hE;
	localparam logic [3:0] SW_FWD_REV     = 4'h3;
	localparam logic [3:0] SW_FAST_SLOW   = 4'hC;
	localparam logic [3:0] SW_FWD_RELEASE = 4'h4;
	localparam logic [3:0] SW_ALL         = 4'h0;

	// Half-step coil nibbles, index 0 in the lowest bits
	localparam logic [31:0] COIL_PATTERN =
		{4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9, 4'h8, 4'hA};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h0;  // [3:0] switch_levels
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [3:0] coil_drive, [6:4] step_position, [22:7] step_period, [23] coils_released
	logic [23:0] m_axis_tdata;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [hsjog_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [15:0] cfg_data      = 16'h0;

	// Shadow of the jog controller
	hsjog_pkg::reg_t    floor_q    = hsjog_pkg::RATE_FLOOR_RST;
	hsjog_pkg::reg_t    ceil_q     = hsjog_pkg::RATE_CEILING_RST;
	hsjog_pkg::period_t period_q   =
		hsjog_pkg::PERIOD_BITS'(hsjog_pkg::START_RATE_RST);
	hsjog_pkg::period_t tick_q     = '0;
	logic [2:0]         phase_q    = 3'd0;
	logic               released_q = 1'b0;

	hsjog_pkg::result_t coil_expect [$];
	int      steps_seen = 0;
	int      items_sent = 0;
	int      fail_count = 0;
	bit      tx_burst   = 1'b0;
	bit      rx_burst   = 1'b0;
	int      rx_hold    = 0;

	half_step_stepper_jog_control_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Advance the step timer by one tick; queue the step result when it expires
	function automatic void predict_tick(input logic [3:0] levels);
		logic [3:0]                      pressed;
		logic [hsjog_pkg::PERIOD_BITS:0] grown;
		hsjog_pkg::result_t              r;
		pressed = ~levels;
		if (tick_q < period_q) begin
			tick_q = tick_q + 1'b1;
			return;
		end
		tick_q = '0;
		if (pressed[hsjog_pkg::PIN_FWD]) begin
			phase_q    = phase_q + 3'd1;
			released_q = 1'b0;
		end
		if (pressed[hsjog_pkg::PIN_REV]) begin
			phase_q    = phase_q - 3'd1;
			released_q = 1'b0;
		end
		r.coil_drive = released_q ? 4'h0 : COIL_PATTERN[phase_q*4 +: 4];
		if (pressed[hsjog_pkg::PIN_FAST]) begin
			if (period_q > floor_q)
				period_q = hsjog_pkg::PERIOD_BITS'(period_q -
					period_q / hsjog_pkg::SHRINK_DIV);
		end else if (pressed[hsjog_pkg::PIN_SLOW]) begin
			if (period_q < ceil_q) begin
				grown    = (hsjog_pkg::PERIOD_BITS+1)'(period_q +
					period_q / hsjog_pkg::SHRINK_DIV);
				period_q = grown[hsjog_pkg::PERIOD_BITS] ? '1 :
					grown[hsjog_pkg::PERIOD_BITS-1:0];
			end
		end
		if (pressed[hsjog_pkg::PIN_FAST] && pressed[hsjog_pkg::PIN_SLOW])
			released_q = 1'b1;
		r.step_position  = phase_q;
		r.step_period    = hsjog_pkg::REG_BITS'(period_q);
		r.coils_released = released_q;
		coil_expect.push_back(r);
		steps_seen++;
	endfunction

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Offer one tick after a random gap and hold it until accepted
	task automatic send_tick(input logic [3:0] levels);
		int gap;
		gap = draw_gap(tx_burst);
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'h0, levels};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_tick(levels);
		items_sent++;
	endtask

	// Keep ticking with the same levels until the timer has produced a step
	task automatic run_to_step(input logic [3:0] levels);
		int mark;
		mark = steps_seen;
		while (steps_seen == mark) send_tick(levels);
	endtask

	// Drop both request lines and wait for every step result to drain
	task automatic wait_quiet;
		s_axis_tvalid <= 1'b0;
		cfg_valid     <= 1'b0;
		while (coil_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [hsjog_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			hsjog_pkg::REG_START_RATE: begin
				period_q = hsjog_pkg::PERIOD_BITS'(data);
				tick_q   = '0;
			end
			hsjog_pkg::REG_RATE_FLOOR:   floor_q = data;
			hsjog_pkg::REG_RATE_CEILING: ceil_q  = data;
			default: ;
		endcase
	endtask

	// Check each result beat against the oldest predicted step; stall at random
	always @(posedge clk) begin
		hsjog_pkg::result_t got;
		hsjog_pkg::result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = hsjog_pkg::result_t'(m_axis_tdata);
				if (coil_expect.size() == 0) begin
					$error("result beat with no step pending: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = coil_expect.pop_front();
					if (got.coil_drive !== want.coil_drive) begin
						$error("coil_drive expected %h got %h", want.coil_drive, got.coil_drive);
						fail_count++;
					end
					if (got.step_position !== want.step_position) begin
						$error("step_position expected %0d got %0d",
							want.step_position, got.step_position);
						fail_count++;
					end
					if (got.step_period !== want.step_period) begin
						$error("step_period expected %0d got %0d",
							want.step_period, got.step_period);
						fail_count++;
					end
					if (got.coils_released !== want.coils_released) begin
						$error("coils_released expected %b got %b",
							want.coils_released, got.coils_released);
						fail_count++;
					end
				end
				rx_hold = draw_gap(rx_burst);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Reset values: the 12000 period gives no step over the first ticks
	task automatic test_reset_values;
		tx_burst = 1'b1;
		rx_burst = 1'b0;
		repeat (40) send_tick(4'($urandom_range(0, 15)));
		wait_quiet;
	endtask

	// Zero period steps on every tick: walk through the switch combinations
	task automatic test_switch_cases;
		int k;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		cfg_write(hsjog_pkg::REG_RATE_FLOOR, 16'h0000);
		cfg_write(hsjog_pkg::REG_RATE_CEILING, 16'hFFFF);
		cfg_write(hsjog_pkg::REG_START_RATE, 16'h0000);
		send_tick(SW_NONE);
		send_tick(SW_FWD);
		send_tick(SW_FWD);
		send_tick(SW_REV);
		// forward and reverse together keep the index
		send_tick(SW_FWD_REV);
		// release, then coils stay off while released
		send_tick(SW_FAST_SLOW);
		send_tick(SW_NONE);
		send_tick(SW_SLOW);
		send_tick(SW_FWD);
		// release on the same step still shows the nibble
		send_tick(SW_FWD_RELEASE);
		send_tick(SW_FAST);
		send_tick(SW_ALL);
		send_tick(SW_REV);
		// wrap the index forwards and back
		for (k = 0; k < 9; k++) send_tick(SW_FWD);
		send_tick(SW_REV);
		wait_quiet;
	endtask

	// Period 3 gives a step every fourth tick
	task automatic test_step_length;
		cfg_write(hsjog_pkg::REG_START_RATE, 16'd3);
		repeat (12) send_tick(4'($urandom_range(0, 15)));
		wait_quiet;
	endtask

	// Lengthen a period where period/1000 is one, just under the ceiling
	task automatic test_rate_limits;
		tx_burst = 1'b1;
		cfg_write(hsjog_pkg::REG_RATE_FLOOR, 16'd999);
		cfg_write(hsjog_pkg::REG_RATE_CEILING, 16'd1001);
		cfg_write(hsjog_pkg::REG_START_RATE, 16'd1000);
		run_to_step(SW_SLOW);
		wait_quiet;
	endtask

	// Largest values, an unused index, and bounds that lock the period
	task automatic test_register_extremes;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		cfg_write(hsjog_pkg::REG_RATE_FLOOR, 16'hFFFF);
		cfg_write(hsjog_pkg::REG_RATE_CEILING, 16'h0000);
		cfg_write(hsjog_pkg::REG_START_RATE, 16'hFFFF);
		repeat (8) send_tick(4'($urandom_range(0, 15)));
		wait_quiet;
		cfg_write(REG_UNUSED, 16'hFFFF);
		cfg_write(REG_UNUSED, 16'h0000);
		cfg_write(hsjog_pkg::REG_START_RATE, 16'd2);
		repeat (9) send_tick(4'($urandom_range(0, 15)));
		wait_quiet;
	endtask

	// Random switch levels over short random settings, draining between phases
	task automatic test_random_traffic;
		int first;
		int n;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			wait_quiet;
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1))
				cfg_write(hsjog_pkg::REG_RATE_FLOOR, 16'($urandom_range(0, 65535)));
			if ($urandom_range(0, 1))
				cfg_write(hsjog_pkg::REG_RATE_CEILING, 16'($urandom_range(0, 65535)));
			if ($urandom_range(0, 7) == 0)
				cfg_write(REG_UNUSED, 16'($urandom_range(0, 65535)));
			if ($urandom_range(0, 2) != 0)
				cfg_write(hsjog_pkg::REG_START_RATE, ($urandom_range(0, 9) == 0) ?
					16'($urandom_range(0, 60)) : 16'($urandom_range(0, 10)));
			n = $urandom_range(10, 120);
			repeat (n) send_tick(4'($urandom_range(0, 15)));
		end
		wait_quiet;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values;
		test_switch_cases;
		test_step_length;
		test_rate_limits;
		test_register_extremes;
		test_random_traffic;
		wait_quiet;
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Give up long after the slowest correct run
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
